// ----- hw/rtl/ascii_can_frame_parser_macros.svh -----
// Assertion macros shared by the parser RTL.
`ifndef ASCII_CAN_FRAME_PARSER_MACROS_SVH
`define ASCII_CAN_FRAME_PARSER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ACFP_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("acfp assertion failed");
// next-cycle implication
`define ACFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("acfp assertion failed");
`else
`define ACFP_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ACFP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- hw/rtl/acfp_pkg.sv -----
package acfp_pkg;

   localparam logic [7:0] CH_GT    = 8'h3E;  // '>'
   localparam logic [7:0] CH_BANG  = 8'h21;  // '!'
   localparam logic [7:0] CH_COMMA = 8'h2C;  // ','
   localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
   localparam logic [7:0] CH_ONE   = 8'h31;  // '1'
   localparam logic [7:0] CH_EIGHT = 8'h38;  // '8'
   localparam int unsigned ID_CHARS = 8;
   localparam int unsigned TDATA_W  = 104;

   typedef enum logic [2:0] {
      PH_START   = 3'd0,
      PH_BANG    = 3'd1,
      PH_ID      = 3'd2,
      PH_COMMA1  = 3'd3,
      PH_LEN     = 3'd4,
      PH_COMMA2  = 3'd5,
      PH_PAYLOAD = 3'd6
   } phase_type;

   typedef struct packed {
      logic [63:0] data;
      logic [3:0]  length;
      logic [31:0] id;
   } frame_type;

   // non-hex characters decode as zero
   function automatic logic [3:0] hex_nibble(input logic [7:0] c);
      logic [3:0] nib;
      nib = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         nib = c[3:0];
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         nib = c[3:0] + 4'd9;
      end
      return nib;
   endfunction

endpackage

// ----- hw/rtl/acfp_in_reg.sv -----
module acfp_in_reg
   import acfp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       step,
   output logic       byte_valid,
   output logic [7:0] byte_data
);

   logic       valid_ff, valid_in;
   logic [7:0] data_ff;
   logic       take;

   assign req_tready = !valid_ff || step;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (step) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= req_tdata;
      end
   end

   assign byte_valid = valid_ff;
   assign byte_data  = data_ff;

endmodule

// ----- hw/rtl/acfp_parser.sv -----
`include "ascii_can_frame_parser_macros.svh"

module acfp_parser
   import acfp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       byte_valid,
   input  logic [7:0] byte_data,
   input  logic       out_free,
   output logic       step,
   output logic       frame_valid,
   output frame_type  frame
);

   phase_type   phase_ff, phase_in;
   logic [3:0]  count_ff, count_in;
   logic [31:0] id_ff, id_in;
   logic [3:0]  len_ff, len_in;
   logic [63:0] payload_ff, payload_in;
   logic [3:0]  nib;
   logic [3:0]  nib_pos;
   logic [7:0]  len_diff;
   logic        last_char;
   logic        emit;
   logic        len_ok;

   assign nib       = hex_nibble(byte_data);
   assign nib_pos   = {count_ff[3:1], ~count_ff[0]};
   assign len_diff  = byte_data - CH_ZERO;
   assign len_ok    = (byte_data >= CH_ONE) && (byte_data <= CH_EIGHT);
   assign last_char = (({1'b0, count_ff} + 5'd1) == {len_ff, 1'b0});
   assign emit      = (phase_ff == PH_PAYLOAD) && last_char;

   // a frame-ending character waits until the result register has room
   assign step        = byte_valid && (!emit || out_free);
   assign frame_valid = step && emit;

   // next state
   always_comb begin
      phase_in = PH_START;
      unique case (phase_ff)
         PH_BANG:    phase_in = (byte_data == CH_BANG) ? PH_ID : PH_START;
         PH_ID:      phase_in = (count_ff == 4'(ID_CHARS - 1)) ? PH_COMMA1 : PH_ID;
         PH_COMMA1:  phase_in = (byte_data == CH_COMMA) ? PH_LEN : PH_START;
         PH_LEN:     phase_in = len_ok ? PH_COMMA2 : PH_START;
         PH_COMMA2:  phase_in = (byte_data == CH_COMMA) ? PH_PAYLOAD : PH_START;
         PH_PAYLOAD: phase_in = last_char ? PH_START : PH_PAYLOAD;
         default:    phase_in = (byte_data == CH_GT) ? PH_BANG : PH_START;
      endcase
   end

   // datapath
   always_comb begin
      count_in   = count_ff;
      id_in      = id_ff;
      len_in     = len_ff;
      payload_in = payload_ff;
      unique case (phase_ff)
         PH_BANG: begin
            if (byte_data == CH_BANG) begin
               count_in = 4'd0;
               id_in    = 32'd0;
            end
         end
         PH_ID: begin
            id_in    = {id_ff[27:0], nib};
            count_in = count_ff + 4'd1;
         end
         PH_LEN: begin
            if (len_ok) begin
               count_in   = 4'd0;
               len_in     = len_diff[3:0];
               payload_in = 64'd0;
            end
         end
         PH_PAYLOAD: begin
            payload_in = payload_ff | (64'(nib) << {nib_pos, 2'b00});
            count_in   = last_char ? 4'd0 : count_ff + 4'd1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_START;
         count_ff   <= 4'd0;
         id_ff      <= 32'd0;
         len_ff     <= 4'd0;
         payload_ff <= 64'd0;
      end else if (step) begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         id_ff      <= id_in;
         len_ff     <= len_in;
         payload_ff <= payload_in;
      end
   end

   assign frame.id     = id_ff;
   assign frame.length = len_ff;
   assign frame.data   = payload_in;

   `ACFP_ASSERT_IMPLIES(a_emit_len_range, clock, reset, frame_valid,
      (len_ff >= 4'd1) && (len_ff <= 4'd8))
   `ACFP_ASSERT_IMPLIES(a_payload_count, clock, reset, phase_ff == PH_PAYLOAD,
      ({1'b0, count_ff} < {len_ff, 1'b0}))
   `ACFP_ASSERT_NEXT(a_emit_to_start, clock, reset, frame_valid, phase_ff == PH_START)

endmodule

// ----- hw/rtl/acfp_out_reg.sv -----
`include "ascii_can_frame_parser_macros.svh"

module acfp_out_reg
   import acfp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 frame_valid,
   input  frame_type            frame,
   output logic                 out_free,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [TDATA_W-1:0]   rsp_tdata
);

   logic      valid_ff, valid_in;
   frame_type frame_ff;

   assign out_free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (frame_valid) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (frame_valid) begin
         frame_ff <= frame;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {(TDATA_W - $bits(frame_type))'(0), frame_ff};

   `ACFP_ASSERT_IMPLIES(a_no_overwrite, clock, reset, frame_valid,
      !valid_ff || rsp_tready)

endmodule

// ----- hw/rtl/ascii_can_frame_parser.sv -----
// Text-to-CAN frame recognizer.
// req channel: one received ASCII character per item in req_tdata[7:0].
// rsp channel: one decoded frame per item when '>!' + 8 id hex chars + ','
//   + length digit 1..8 + ',' + 2*length payload hex chars has been seen.
//   Malformed prefix, comma or length resets the search for '>'.
// Path: the last payload character is held in the input register, and the
//   parser step runs from there straight into the result register, which
//   drives rsp_tvalid.
// Throughput: one character per cycle while no frame-ending character is held (see Stall).
// Stall: while a frame waits in the result register, characters that do not
//   end a frame keep flowing; a frame-ending character is held in the input
//   register, and req_tready drops, until the result is taken.
// Reset: synchronous, active high; empties both registers and returns the
//   parser to waiting for '>'.
module ascii_can_frame_parser
   import acfp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,   // [7:0] rx_byte
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [TDATA_W-1:0]  rsp_tdata    // [31:0] frame_id, [35:32] frame_length,
                                            // [99:36] frame_data, [103:100] zero
);

   logic      step;
   logic      byte_valid;
   logic [7:0] byte_data;
   logic      out_free;
   logic      frame_valid;
   frame_type frame;

   acfp_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .step       (step),
      .byte_valid (byte_valid),
      .byte_data  (byte_data)
   );

   acfp_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .byte_valid  (byte_valid),
      .byte_data   (byte_data),
      .out_free    (out_free),
      .step        (step),
      .frame_valid (frame_valid),
      .frame       (frame)
   );

   acfp_out_reg u_out_reg (
      .clock       (clock),
      .reset       (reset),
      .frame_valid (frame_valid),
      .frame       (frame),
      .out_free    (out_free),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

// ----- sim/tb_top.sv -----
module tb_top;
   import acfp_pkg::*;

   localparam int STALL_LIMIT  = 4000;
   localparam int RANDOM_CHARS = 1250;
   localparam int DIR_ROWS     = 4;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [7:0]          req_tdata;    // [7:0] rx_byte
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [TDATA_W-1:0]  rsp_tdata;    // [31:0] frame_id, [35:32] frame_length,
                                      // [99:36] frame_data, [103:100] zero

   ascii_can_frame_parser u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #4 clock = ~clock;

   // directed table; '~' in a row stands for a zero byte
   string dir_text [DIR_ROWS] = '{
      ">!FFFFFFFF,8,FFFFFFFFFFFFFFFF",
      ">>!>!~x>,Z\377aB,1,>,",
      ">!1234abcd,9>!1234abcd,1;",
      ">!0123cdEF,2,a5C3"
   };
   bit        dir_typed [DIR_ROWS] = '{1'b1, 1'b1, 1'b0, 1'b0};
   frame_type dir_frame [DIR_ROWS] = '{
      {64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'hFFFF_FFFF},
      {64'h0, 4'd1, 32'h0000_00AB},
      '0,
      '0
   };

   string hex_chars = "0123456789abcdefABCDEF";

   // parser image
   phase_type   ph      = PH_START;
   logic [3:0]  cnt     = '0;
   logic [31:0] id_acc  = '0;
   logic [3:0]  nbytes  = '0;
   logic [63:0] pay     = '0;

   frame_type   frames_due [$];
   int          fault_count = 0;
   int          sent = 0;
   int          idle_cycles = 0;
   bit          req_quiet = 1'b0;

   function automatic logic [3:0] char_value(input logic [7:0] c);
      logic [3:0] v;
      v = 4'd0;
      if (c >= CH_ZERO && c <= "9") begin
         v = 4'(c - CH_ZERO);
      end else if (c >= "a" && c <= "f") begin
         v = 4'(c - "a" + 8'd10);
      end else if (c >= "A" && c <= "F") begin
         v = 4'(c - "A" + 8'd10);
      end
      return v;
   endfunction

   // one character through the parser image; returns 1 when a frame completes
   function automatic bit parse_char(input logic [7:0] c, output frame_type fr);
      int idx;
      int sh;
      bit made;
      made = 1'b0;
      fr = '0;
      case (ph)
         PH_BANG: begin
            if (c == CH_BANG) begin
               ph = PH_ID;
               cnt = '0;
               id_acc = '0;
            end else begin
               ph = PH_START;
            end
         end
         PH_ID: begin
            id_acc = {id_acc[27:0], char_value(c)};
            cnt = cnt + 4'd1;
            if (cnt == 4'(ID_CHARS)) begin
               ph = PH_COMMA1;
            end
         end
         PH_COMMA1: ph = (c == CH_COMMA) ? PH_LEN : PH_START;
         PH_LEN: begin
            if (c >= CH_ONE && c <= CH_EIGHT) begin
               ph = PH_COMMA2;
               cnt = '0;
               nbytes = 4'(c - CH_ZERO);
               pay = '0;
            end else begin
               ph = PH_START;
            end
         end
         PH_COMMA2: ph = (c == CH_COMMA) ? PH_PAYLOAD : PH_START;
         PH_PAYLOAD: begin
            idx = int'(cnt);
            // even characters are the high nibble of their byte
            sh = 8 * (idx / 2) + ((idx % 2 == 0) ? 4 : 0);
            pay = pay | (64'(char_value(c)) << sh);
            if (idx + 1 == 2 * int'(nbytes)) begin
               fr.id = id_acc;
               fr.length = nbytes;
               fr.data = pay;
               made = 1'b1;
               ph = PH_START;
               cnt = '0;
            end else begin
               cnt = cnt + 4'd1;
            end
         end
         default: ph = (c == CH_GT) ? PH_BANG : PH_START;
      endcase
      return made;
   endfunction

   function automatic int gap_len(input bit quiet);
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) begin
         return 0;
      end
      if (r < 93) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(6, 40);
   endfunction

   function automatic void log_fault(input string msg);
      fault_count++;
      if (fault_count <= 10) begin
         $display("mismatch: %s", msg);
      end
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_char(input logic [7:0] c, input bit typed, input frame_type typed_fr);
      int n;
      frame_type fr;
      n = gap_len(req_quiet);
      if (n != 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      do @(posedge clock); while (!req_tready);
      sent++;
      if (parse_char(c, fr)) begin
         frames_due.push_back(typed ? typed_fr : fr);
      end
      @(negedge clock);
   endtask

   function automatic logic [7:0] rand_data_char();
      if ($urandom_range(0, 15) == 0) begin
         return 8'($urandom_range(0, 255));
      end
      return hex_chars[$urandom_range(0, hex_chars.len() - 1)];
   endfunction

   // mostly well-formed frames, some cut short, some with a broken field, some noise
   task automatic send_random_run();
      logic [7:0] q [$];
      int len;
      int mode;
      int k;
      int cut;
      len = $urandom_range(1, 8);
      mode = $urandom_range(0, 9);
      if (mode == 2) begin
         repeat ($urandom_range(1, 6)) q.push_back(8'($urandom_range(0, 255)));
      end else begin
         q.push_back(CH_GT);
         q.push_back(CH_BANG);
         repeat (ID_CHARS) q.push_back(rand_data_char());
         q.push_back(CH_COMMA);
         q.push_back(CH_ZERO + 8'(len));
         q.push_back(CH_COMMA);
         repeat (2 * len) q.push_back(rand_data_char());
         if (mode == 0) begin
            cut = $urandom_range(1, q.size() - 1);
            q = q[0:cut-1];
         end else if (mode == 1) begin
            case ($urandom_range(0, 3))
               0: k = 1;
               1: k = 10;
               2: k = 11;
               default: k = 12;
            endcase
            if (k == 11 && $urandom_range(0, 1) == 0) begin
               q[k] = $urandom_range(0, 1) ? "9" : CH_ZERO;
            end else begin
               q[k] = 8'($urandom_range(0, 255));
            end
         end
      end
      foreach (q[i]) begin
         send_char(q[i], 1'b0, '0);
      end
   endtask

   initial begin
      logic [7:0] ch;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int r = 0; r < DIR_ROWS; r++) begin
         for (int k = 0; k < dir_text[r].len(); k++) begin
            ch = dir_text[r][k];
            if (ch == "~") begin
               ch = 8'h00;
            end
            send_char(ch, dir_typed[r], dir_frame[r]);
         end
      end

      sent = 0;
      while (sent < RANDOM_CHARS) begin
         if ($urandom_range(0, 3) == 0) begin
            req_quiet = !req_quiet;
         end
         send_random_run();
      end
      req_tvalid <= 1'b0;

      while (frames_due.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (fault_count == 0 && frames_due.size() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

   // result side back-pressure
   initial begin
      int n;
      bit quiet;
      quiet = 1'b0;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if ($urandom_range(0, 7) == 0) begin
            quiet = !quiet;
         end
         n = gap_len(quiet);
         if (n != 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
   end

   always @(posedge clock) begin
      frame_type got;
      frame_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = frame_type'(rsp_tdata[99:0]);
         if (frames_due.size() == 0) begin
            log_fault($sformatf("frame with none pending: id %h len %0d data %h",
                                got.id, got.length, got.data));
         end else begin
            want = frames_due.pop_front();
            if (got.id !== want.id) begin
               log_fault($sformatf("frame_id expected %h got %h", want.id, got.id));
            end
            if (got.length !== want.length) begin
               log_fault($sformatf("frame_length expected %0d got %0d",
                                   want.length, got.length));
            end
            if (got.data !== want.data) begin
               log_fault($sformatf("frame_data expected %h got %h", want.data, got.data));
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
         $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
         $display("tb_top failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
